/* hdl/accel_lowpass_jerk_defines.svh */
// ---------------------------------------------------------------------------
// accel_lowpass_jerk_defines
// Assertion macros shared by the accelerometer filter block.
// ---------------------------------------------------------------------------
`ifndef ACCEL_LOWPASS_JERK_DEFINES_SVH
`define ACCEL_LOWPASS_JERK_DEFINES_SVH

// same-cycle implication
`define ALJ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ALJ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/alj_pkg.sv */
// ---------------------------------------------------------------------------
// alj_pkg
// Types and constants of the accelerometer low-pass and jerk block.
// ---------------------------------------------------------------------------
package alj_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int TICK_BITS      = 32;
   localparam int JERK_BITS      = 32;
   localparam int BETA_BITS      = 3;
   localparam int CLOCK_BITS     = 30;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [BETA_BITS-1:0]  BETA_RESET     = 3'd2;
   localparam logic [CLOCK_BITS-1:0] CLOCK_RESET    = 30'd400000000;
   localparam logic [TICK_BITS-1:0]  SAMPLING_RESET = 32'd16000000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BETA_SHIFT     = 2'd0,
      CSR_CLOCK_RATE     = 2'd1,
      CSR_SAMPLING_TICKS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILTER,
      ST_DIFF,
      ST_LAUNCH,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_x;
      logic signed [SAMPLE_BITS-1:0] sample_y;
      logic signed [SAMPLE_BITS-1:0] sample_z;
      logic [TICK_BITS-1:0]          tick_stamp;
      logic                          enable;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] filtered_x;
      logic signed [SAMPLE_BITS-1:0] filtered_y;
      logic signed [SAMPLE_BITS-1:0] filtered_z;
      logic signed [JERK_BITS-1:0]   jerk_x;
      logic signed [JERK_BITS-1:0]   jerk_y;
      logic signed [JERK_BITS-1:0]   jerk_z;
      logic                          saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic done;
      logic sat;
   } lane_status_type;

endpackage

/* hdl/alj_serial_mul.sv */
// ---------------------------------------------------------------------------
// alj_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module alj_serial_mul #(
   parameter int A_WIDTH = 25,
   parameter int B_WIDTH = 30
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [A_WIDTH-1:0]         a,
   input  logic [B_WIDTH-1:0]         b,
   output logic                       done,
   output logic [A_WIDTH+B_WIDTH-1:0] product
);

   localparam int CNT_W = $clog2(B_WIDTH + 1);

   logic [A_WIDTH-1:0] mcand_ff, mcand_in;
   logic [A_WIDTH-1:0] acc_ff, acc_in;
   logic [B_WIDTH-1:0] mplier_ff, mplier_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [A_WIDTH:0]   sum;

   always_comb begin
      sum       = {1'b0, acc_ff} + (mplier_ff[0] ? {1'b0, mcand_ff} : '0);
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = a;
         acc_in    = '0;
         mplier_in = b;
         cnt_in    = CNT_W'(B_WIDTH);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = sum[A_WIDTH:1];
         mplier_in = {sum[0], mplier_ff[B_WIDTH-1:1]};
         cnt_in    = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = {acc_ff, mplier_ff};

endmodule

/* hdl/alj_serial_div.sv */
// ---------------------------------------------------------------------------
// alj_serial_div
// Restoring divider, one dividend bit per cycle, with quotient overflow flag.
// ---------------------------------------------------------------------------
module alj_serial_div #(
   parameter int N_WIDTH = 47,
   parameter int D_WIDTH = 32,
   parameter int Q_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [N_WIDTH-1:0] num,
   input  logic [D_WIDTH-1:0] den,
   output logic               done,
   output logic [Q_WIDTH-1:0] quotient,
   output logic               overflow
);

   localparam int CNT_W = $clog2(N_WIDTH + 1);

   logic [N_WIDTH-1:0] num_ff, num_in;
   logic [D_WIDTH-1:0] den_ff, den_in;
   logic [D_WIDTH-1:0] rem_ff, rem_in;
   logic [Q_WIDTH-1:0] quo_ff, quo_in;
   logic               over_ff, over_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [D_WIDTH:0]   trial;
   logic [D_WIDTH+1:0] sub;
   logic               take;

   always_comb begin
      trial   = {rem_ff, num_ff[N_WIDTH-1]};
      sub     = {1'b0, trial} - {2'b00, den_ff};
      take    = ~sub[D_WIDTH+1];
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      over_in = over_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
         over_in = 1'b0;
         cnt_in  = CNT_W'(N_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = num_ff << 1;
         rem_in  = take ? sub[D_WIDTH-1:0] : trial[D_WIDTH-1:0];
         quo_in  = {quo_ff[Q_WIDTH-2:0], take};
         over_in = over_ff | quo_ff[Q_WIDTH-1];
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      over_ff <= over_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign overflow = over_ff;

endmodule

/* hdl/alj_jerk_lane.sv */
// ---------------------------------------------------------------------------
// alj_jerk_lane
// One axis of jerk: |diff| * clock_rate, drop fraction bits, divide by the
// tick gap, then restore sign and saturate to 32 bits.
// ---------------------------------------------------------------------------
module alj_jerk_lane #(
   parameter int MAG_WIDTH = 25,
   parameter int FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [MAG_WIDTH-1:0]         diff,
   input  logic [alj_pkg::CLOCK_BITS-1:0]      clock_rate,
   input  logic [alj_pkg::TICK_BITS-1:0]       gap,
   output logic [alj_pkg::JERK_BITS-1:0]       jerk,
   output alj_pkg::lane_status_type            status
);

   import alj_pkg::*;

   localparam int PROD_W = MAG_WIDTH + CLOCK_BITS;
   localparam int NUM_W  = PROD_W - FRAC_BITS;

   logic [MAG_WIDTH-1:0] mag;
   logic                 neg_ff, neg_in;
   logic                 mul_done;
   logic [PROD_W-1:0]    product;
   logic                 div_done;
   logic [JERK_BITS-1:0] quo;
   logic                 over;
   logic [JERK_BITS-1:0] limit;
   logic                 clip;
   logic [JERK_BITS-1:0] jerk_ff, jerk_in;
   logic                 sat_ff, sat_in;
   logic                 done_ff, done_in;

   assign mag = diff[MAG_WIDTH-1] ? MAG_WIDTH'(-diff) : MAG_WIDTH'(diff);

   alj_serial_mul #(
      .A_WIDTH(MAG_WIDTH),
      .B_WIDTH(CLOCK_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .a      (mag),
      .b      (clock_rate),
      .done   (mul_done),
      .product(product)
   );

   alj_serial_div #(
      .N_WIDTH(NUM_W),
      .D_WIDTH(TICK_BITS),
      .Q_WIDTH(JERK_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_done),
      .num     (product[PROD_W-1:FRAC_BITS]),
      .den     (gap),
      .done    (div_done),
      .quotient(quo),
      .overflow(over)
   );

   always_comb begin
      limit   = neg_ff ? {1'b1, {(JERK_BITS-1){1'b0}}} : {1'b0, {(JERK_BITS-1){1'b1}}};
      clip    = over | (quo > limit);
      neg_in  = start ? diff[MAG_WIDTH-1] : neg_ff;
      jerk_in = jerk_ff;
      sat_in  = sat_ff;
      done_in = div_done;
      if (div_done) begin
         sat_in = clip;
         if (clip) begin
            jerk_in = limit;
         end else begin
            jerk_in = neg_ff ? -quo : quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      jerk_ff <= jerk_in;
      sat_ff  <= sat_in;
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign jerk        = jerk_ff;
   assign status.done = done_ff;
   assign status.sat  = sat_ff;

endmodule

/* hdl/accel_lowpass_jerk.sv */
// ---------------------------------------------------------------------------
// accel_lowpass_jerk
// Three-axis accelerometer low-pass filter with serial jerk estimate.
//
//   channel  ports                          beat
//   req      req_valid req_stall req_payload  one raw sample, tick, enable
//   rsp      rsp_valid rsp_stall rsp_payload  filtered axes, jerk, clip flag
//   csr      csr_we csr_index csr_wdata       one register write
//
// A disabled or too-early beat is taken in ST_IDLE and leaves req free.
// An update beat steps from its accept through ST_FILTER, ST_DIFF, ST_LAUNCH
// and ST_RUN to ST_DONE, which loads rsp_valid; req is stalled until ST_DONE
// is left. The three axis lanes run side by side, each with its bit-serial
// multiply by clock_rate and then bit-serial divide of the product by the gap.
// A finished result sits in the rsp register, so req is free again while it
// waits; a next result waits in ST_DONE until rsp drains.
// Reset is synchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
`include "accel_lowpass_jerk_defines.svh"

module accel_lowpass_jerk #(
   parameter int EXTRA_FRACTION_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  alj_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output alj_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_we,
   input  logic [alj_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [alj_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   import alj_pkg::*;

   localparam int W = SAMPLE_BITS + EXTRA_FRACTION_BITS;

   state_type state_ff, state_in;

   logic [BETA_BITS-1:0]  beta_ff, beta_in;
   logic [CLOCK_BITS-1:0] clock_rate_ff, clock_rate_in;
   logic [TICK_BITS-1:0]  sampling_ff, sampling_in;

   logic signed [W-1:0]   filter_ff [3];
   logic signed [W-1:0]   filter_in [3];
   logic signed [W-1:0]   prev_ff   [3];
   logic signed [W-1:0]   prev_in   [3];
   logic signed [W-1:0]   raw_ff    [3];
   logic signed [W-1:0]   raw_in    [3];
   logic signed [W:0]     diff_ff   [3];
   logic signed [W:0]     diff_in   [3];
   logic signed [W-1:0]   raw       [3];
   logic signed [W:0]     delta     [3];
   logic signed [W:0]     step      [3];
   logic [TICK_BITS-1:0]  prev_tick_ff, prev_tick_in;
   logic [TICK_BITS-1:0]  gap_ff, gap_in;
   logic [TICK_BITS-1:0]  gap;
   logic                  gap_ok;

   rsp_payload_type       rsp_payload_ff, rsp_payload_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_accept;
   logic                  lane_start;
   logic                  rsp_load;
   logic                  lanes_done;
   logic [JERK_BITS-1:0]  jerk [3];
   lane_status_type       lane_status [3];

   // configuration
   always_comb begin
      beta_in       = beta_ff;
      clock_rate_in = clock_rate_ff;
      sampling_in   = sampling_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BETA_SHIFT:     beta_in       = csr_wdata[BETA_BITS-1:0];
            CSR_CLOCK_RATE:     clock_rate_in = csr_wdata[CLOCK_BITS-1:0];
            CSR_SAMPLING_TICKS: sampling_in   = csr_wdata[TICK_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign req_accept = req_valid & ~req_stall;
   assign gap        = req_payload.tick_stamp - prev_tick_ff;
   assign gap_ok     = gap >= sampling_ff;
   assign lanes_done = lane_status[0].done & lane_status[1].done & lane_status[2].done;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_payload.enable && gap_ok) state_in = ST_FILTER;
         end
         ST_FILTER: state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_RUN;
         ST_RUN: begin
            if (lanes_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall  = 1'b1;
      lane_start = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall  = 1'b0;
         ST_LAUNCH: lane_start = 1'b1;
         ST_DONE:   rsp_load   = ~rsp_valid_ff | ~rsp_stall;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      raw[0] = W'(req_payload.sample_x) <<< EXTRA_FRACTION_BITS;
      raw[1] = W'(req_payload.sample_y) <<< EXTRA_FRACTION_BITS;
      raw[2] = W'(req_payload.sample_z) <<< EXTRA_FRACTION_BITS;
      prev_tick_in = prev_tick_ff;
      gap_in       = gap_ff;
      for (int i = 0; i < 3; i++) begin
         delta[i]     = (W+1)'(filter_ff[i]) - (W+1)'(raw_ff[i]);
         step[i]      = delta[i] >>> beta_ff;
         filter_in[i] = filter_ff[i];
         prev_in[i]   = prev_ff[i];
         raw_in[i]    = raw_ff[i];
         diff_in[i]   = diff_ff[i];
      end
      if (state_ff == ST_IDLE && req_accept) begin
         if (!req_payload.enable) begin
            for (int i = 0; i < 3; i++) prev_in[i] = raw[i];
            prev_tick_in = req_payload.tick_stamp;
         end else if (gap_ok) begin
            for (int i = 0; i < 3; i++) raw_in[i] = raw[i];
            prev_tick_in = req_payload.tick_stamp;
            gap_in       = (gap == '0) ? TICK_BITS'(1) : gap;
         end
      end
      if (state_ff == ST_FILTER) begin
         for (int i = 0; i < 3; i++) filter_in[i] = W'((W+1)'(filter_ff[i]) - step[i]);
      end
      if (state_ff == ST_DIFF) begin
         for (int i = 0; i < 3; i++) begin
            diff_in[i] = (W+1)'(filter_ff[i]) - (W+1)'(prev_ff[i]);
            prev_in[i] = filter_ff[i];
         end
      end
   end

   // output register
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      if (rsp_load) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.filtered_x = filter_ff[0][W-1:EXTRA_FRACTION_BITS];
         rsp_payload_in.filtered_y = filter_ff[1][W-1:EXTRA_FRACTION_BITS];
         rsp_payload_in.filtered_z = filter_ff[2][W-1:EXTRA_FRACTION_BITS];
         rsp_payload_in.jerk_x     = jerk[0];
         rsp_payload_in.jerk_y     = jerk[1];
         rsp_payload_in.jerk_z     = jerk[2];
         rsp_payload_in.saturated  = lane_status[0].sat | lane_status[1].sat |
                                     lane_status[2].sat;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff         <= gap_in;
      rsp_payload_ff <= rsp_payload_in;
      for (int i = 0; i < 3; i++) begin
         raw_ff[i]  <= raw_in[i];
         diff_ff[i] <= diff_in[i];
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         beta_ff       <= BETA_RESET;
         clock_rate_ff <= CLOCK_RESET;
         sampling_ff   <= SAMPLING_RESET;
         prev_tick_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            filter_ff[i] <= '0;
            prev_ff[i]   <= '0;
         end
      end else begin
         state_ff      <= state_in;
         beta_ff       <= beta_in;
         clock_rate_ff <= clock_rate_in;
         sampling_ff   <= sampling_in;
         prev_tick_ff  <= prev_tick_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int i = 0; i < 3; i++) begin
            filter_ff[i] <= filter_in[i];
            prev_ff[i]   <= prev_in[i];
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      alj_jerk_lane #(
         .MAG_WIDTH(W + 1),
         .FRAC_BITS(EXTRA_FRACTION_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .start     (lane_start),
         .diff      (diff_ff[g]),
         .clock_rate(clock_rate_ff),
         .gap       (gap_ff),
         .jerk      (jerk[g]),
         .status    (lane_status[g])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   `ALJ_ASSERT_IMPLY(a_lanes_in_step, clock, reset, lane_status[0].done,
      lane_status[1].done && lane_status[2].done, "jerk lanes finished out of step")
   `ALJ_ASSERT_IMPLY(a_done_in_run, clock, reset, lane_status[0].done,
      state_ff == ST_RUN, "lane finished outside of run state")
   `ALJ_ASSERT_NEXT(a_launch_busy, clock, reset, state_ff == ST_LAUNCH,
      !lanes_done && state_ff == ST_RUN, "lanes reported done right after launch")
   `ALJ_ASSERT_IMPLY(a_sat_at_limit, clock, reset, rsp_valid_ff && rsp_payload_ff.saturated,
      rsp_payload_ff.jerk_x == 32'sh7FFFFFFF || rsp_payload_ff.jerk_x == 32'sh80000000 ||
      rsp_payload_ff.jerk_y == 32'sh7FFFFFFF || rsp_payload_ff.jerk_y == 32'sh80000000 ||
      rsp_payload_ff.jerk_z == 32'sh7FFFFFFF || rsp_payload_ff.jerk_z == 32'sh80000000,
      "saturated flag without a clipped jerk")

endmodule
